@@ sv/ycc2rgb_pkg.sv @@
// Shared types, constants and helpers for the YCbCr 4:2:0 to RGB converter.
// Holds the Q16 matrix coefficients, line store geometry and limit functions.
// No dependencies.
package ycc2rgb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_ROWS   = 4096;
    localparam int LINE_DEPTH = 2048;
    localparam int PAIR_LIMIT = (MAX_WIDTH / 2 > LINE_DEPTH) ? LINE_DEPTH : MAX_WIDTH / 2;

    localparam int CFG_W   = 13;
    localparam int COL_W   = $clog2(LINE_DEPTH);
    localparam int ROW_W   = 12;
    localparam int PAIRS_W = COL_W + 1;
    localparam int ROWS_W  = ROW_W + 1;
    localparam int PROD_W  = 28;

    // Register indexes of the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef logic signed [PROD_W-1:0] t_prod;

    // Q16 coefficients, rounded to nearest
    localparam t_prod KY  = 28'sd76309;
    localparam t_prod KRV = 28'sd104597;
    localparam t_prod KGU = 28'sd25675;
    localparam t_prod KGV = 28'sd53279;
    localparam t_prod KBU = 28'sd132201;

    localparam logic [8:0] LUMA_OFFSET   = 9'd16;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_flags;

    // Pairs per row from the width register: round up, at least one, at most the store depth
    function automatic logic [PAIRS_W-1:0] pairs_from_width(input logic [CFG_W-1:0] w);
        logic [CFG_W:0] half;
        half = ({1'b0, w} + (CFG_W+1)'(1)) >> 1;
        if (half == '0) begin
            return PAIRS_W'(1);
        end else if (half > (CFG_W+1)'(PAIR_LIMIT)) begin
            return PAIRS_W'(PAIR_LIMIT);
        end
        return half[PAIRS_W-1:0];
    endfunction

    // Rows per frame from the height register: at least one, at most MAX_ROWS
    function automatic logic [ROWS_W-1:0] rows_from_height(input logic [CFG_W-1:0] h);
        if (h == '0) begin
            return ROWS_W'(1);
        end else if (h > CFG_W'(MAX_ROWS)) begin
            return ROWS_W'(MAX_ROWS);
        end
        return h[ROWS_W-1:0];
    endfunction

    // Negative gives zero, else drop the fraction and saturate at 255
    function automatic logic [7:0] clamp_q16(input t_prod v);
        if (v[PROD_W-1]) begin
            return 8'd0;
        end else if (|v[PROD_W-2:24]) begin
            return 8'hFF;
        end
        return v[23:16];
    endfunction

endpackage

@@ sv/ycc2rgb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ycc2rgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ycbcr420_to_rgb_converter_unit.sv @@
// Top level of the BT.601 YCbCr 4:2:0 to RGB converter.
// Depends on ycc2rgb_pkg and ycc2rgb_ram.
//
// The unit takes one word per clock while o_ready is high, each a horizontal
// luma pair in raster order plus one Cb/Cr sample, and returns one word per
// pair with two RGB pixels and row/frame end flags. Sustained rate is one pair
// per clock while i_ready stays high and i_valid keeps up. Even rows
// write their chroma into a 2048 x 16 line store at the pair's column (one write
// port); odd rows read it back through the read port, whose registered output
// lines up with the first pipeline stage. The line store is not cleared after
// reset: an odd row must follow an even row that wrote the same columns, and the
// unit accepts input right out of reset. Stage 1 forms the six Q16 products,
// stage 2 sums and clamps, stage 3 is the output register; each stage advances
// whenever the stage after it is empty or moving, so bubbles collapse and input
// is taken while a finished word waits at the output. Write frame_width and
// frame_height only while the unit is idle; widths are rounded up to whole pairs
// and limited to the line store, heights limited to 1..4096.
module ycbcr420_to_rgb_converter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ycc2rgb_pkg::CFG_W-1:0] i_cfg_data,
    // Input word
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_luma_first,
    input  logic [7:0]                    i_luma_second,
    input  logic [7:0]                    i_blue_chroma,
    input  logic [7:0]                    i_red_chroma,
    // Output word
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_red_first,
    output logic [7:0]                    o_green_first,
    output logic [7:0]                    o_blue_first,
    output logic [7:0]                    o_red_second,
    output logic [7:0]                    o_green_second,
    output logic [7:0]                    o_blue_second,
    output logic                          o_row_end,
    output logic                          o_frame_end
);

    import ycc2rgb_pkg::*;

    // Configuration, held as derived limits
    logic [PAIRS_W-1:0] r_pairs;
    logic [ROWS_W-1:0]  r_rows;

    // Position counters
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Pipeline valids and stage moves
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic accept;

    // Stage 1
    logic [7:0] r_s1_y0, r_s1_y1, r_s1_cb, r_s1_cr;
    logic       r_s1_odd;
    t_flags     r_s1_flags;

    // Stage 2
    t_prod  r_s2_ys0, r_s2_ys1, r_s2_prv, r_s2_pgu, r_s2_pgv, r_s2_pbu;
    t_flags r_s2_flags;

    // Stage 3 (output)
    logic [7:0] r_r0, r_g0, r_b0, r_r1, r_g1, r_b1;
    t_flags     r_s3_flags;

    logic        last_col, last_row;
    t_flags      n_flags;
    logic [15:0] ram_rdata;
    logic [7:0]  cb, cr;
    logic signed [8:0] yd0, yd1, ud, vd;
    t_prod n_ys0, n_ys1, n_prv, n_pgu, n_pgv, n_pbu;
    t_prod sum_r0, sum_g0, sum_b0, sum_r1, sum_g1, sum_b1;

    // A stage may load when it is empty or its contents move on
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign accept  = i_valid && rdy1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= pairs_from_width(WIDTH_RESET);
            r_rows  <= rows_from_height(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_pairs <= pairs_from_width(i_cfg_data);
                REG_FRAME_HEIGHT: r_rows  <= rows_from_height(i_cfg_data);
                default: ;
            endcase
        end
    end

    // End of row and frame for the word being accepted
    assign last_col          = ({1'b0, r_col} + PAIRS_W'(1)) >= r_pairs;
    assign last_row          = ({1'b0, r_row} + ROWS_W'(1)) >= r_rows;
    assign n_flags.row_end   = last_col;
    assign n_flags.frame_end = last_col && last_row;

    // Advance column and row on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Chroma line store: even rows write, odd rows read at the same column
    ycc2rgb_ram #(
        .WIDTH (16),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept && !r_row[0]),
        .i_waddr (r_col),
        .i_wdata ({i_red_chroma, i_blue_chroma}),
        .i_re    (accept && r_row[0]),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: capture the word; the store read lands alongside it
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_y0    <= i_luma_first;
            r_s1_y1    <= i_luma_second;
            r_s1_cb    <= i_blue_chroma;
            r_s1_cr    <= i_red_chroma;
            r_s1_odd   <= r_row[0];
            r_s1_flags <= n_flags;
        end
    end

    // Odd rows take the stored sample; the read data holds until the next accept
    assign cb  = r_s1_odd ? ram_rdata[7:0]  : r_s1_cb;
    assign cr  = r_s1_odd ? ram_rdata[15:8] : r_s1_cr;
    assign yd0 = signed'({1'b0, r_s1_y0}) - signed'(LUMA_OFFSET);
    assign yd1 = signed'({1'b0, r_s1_y1}) - signed'(LUMA_OFFSET);
    assign ud  = signed'({1'b0, cb}) - signed'(CHROMA_OFFSET);
    assign vd  = signed'({1'b0, cr}) - signed'(CHROMA_OFFSET);

    assign n_ys0 = KY  * t_prod'(yd0);
    assign n_ys1 = KY  * t_prod'(yd1);
    assign n_prv = KRV * t_prod'(vd);
    assign n_pgu = KGU * t_prod'(ud);
    assign n_pgv = KGV * t_prod'(vd);
    assign n_pbu = KBU * t_prod'(ud);

    // Stage 2: register the products
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_ys0   <= n_ys0;
            r_s2_ys1   <= n_ys1;
            r_s2_prv   <= n_prv;
            r_s2_pgu   <= n_pgu;
            r_s2_pgv   <= n_pgv;
            r_s2_pbu   <= n_pbu;
            r_s2_flags <= r_s1_flags;
        end
    end

    assign sum_r0 = r_s2_ys0 + r_s2_prv;
    assign sum_g0 = r_s2_ys0 - r_s2_pgu - r_s2_pgv;
    assign sum_b0 = r_s2_ys0 + r_s2_pbu;
    assign sum_r1 = r_s2_ys1 + r_s2_prv;
    assign sum_g1 = r_s2_ys1 - r_s2_pgu - r_s2_pgv;
    assign sum_b1 = r_s2_ys1 + r_s2_pbu;

    // Stage 3: clamp into the output register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_r0       <= clamp_q16(sum_r0);
            r_g0       <= clamp_q16(sum_g0);
            r_b0       <= clamp_q16(sum_b0);
            r_r1       <= clamp_q16(sum_r1);
            r_g1       <= clamp_q16(sum_g1);
            r_b1       <= clamp_q16(sum_b1);
            r_s3_flags <= r_s2_flags;
        end
    end

    assign o_valid        = r_v3;
    assign o_red_first    = r_r0;
    assign o_green_first  = r_g0;
    assign o_blue_first   = r_b0;
    assign o_red_second   = r_r1;
    assign o_green_second = r_g1;
    assign o_blue_second  = r_b1;
    assign o_row_end      = r_s3_flags.row_end;
    assign o_frame_end    = r_s3_flags.frame_end;

endmodule

@@ sv/ycc2rgb_checker.sv @@
// Port-level checks for the YCbCr 4:2:0 to RGB converter, bound to its top level.
// Depends on ycbcr420_to_rgb_converter_unit.
module ycc2rgb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red_first,
    input logic [7:0] o_green_second,
    input logic       o_row_end,
    input logic       o_frame_end
);

    // A frame end is always also a row end
    a_frame_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_end || !o_frame_end))
        else $error("frame end without row end");

    // An empty output stage means the whole pipeline can take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output is empty");

    // Reset drains the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word present right after reset");

    // A stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_red_first)
            && $stable(o_green_second) && $stable(o_row_end)))
        else $error("stalled output word changed");

endmodule

bind ycbcr420_to_rgb_converter_unit ycc2rgb_checker u_ycc2rgb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_red_first    (o_red_first),
    .o_green_second (o_green_second),
    .o_row_end      (o_row_end),
    .o_frame_end    (o_frame_end)
);

@@ test/tb_ycbcr420_to_rgb_converter_unit.sv @@
// Self-checking testbench for the BT.601 YCbCr 4:2:0 to RGB converter unit.
// Predicts every output word in Q16 arithmetic and compares it field by field.
// Depends on ycc2rgb_pkg and the converter RTL.
module tb_ycbcr420_to_rgb_converter_unit;

    import ycc2rgb_pkg::*;

    // Q16 matrix coefficients, studio-range BT.601
    localparam int COEF_Y  = 76309;
    localparam int COEF_RV = 104597;
    localparam int COEF_GU = 25675;
    localparam int COEF_GV = 53279;
    localparam int COEF_BU = 132201;

    localparam int LONG_HOLD   = 160;   // receiver hold-off that fills the pipeline
    localparam int STALL_LIMIT = 4000;  // cycles in which no word moves on either side
    localparam int RANDOM_GOAL = 1350;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] blue_chroma;
        logic [7:0] red_chroma;
    } t_ycc_pair;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       row_end;
        logic       frame_end;
    } t_rgb_pair;

    // ------------------------------------------------------------------
    // Block ports; every input is driven to a known value from time zero
    // ------------------------------------------------------------------
    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic             i_cfg_index    = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] i_cfg_data     = '0;
    logic             i_valid        = 1'b0;
    logic             o_ready;
    logic [7:0]       i_luma_first   = '0;
    logic [7:0]       i_luma_second  = '0;
    logic [7:0]       i_blue_chroma  = '0;
    logic [7:0]       i_red_chroma   = '0;
    logic             o_valid;
    logic             i_ready        = 1'b0;
    logic [7:0]       o_red_first;
    logic [7:0]       o_green_first;
    logic [7:0]       o_blue_first;
    logic [7:0]       o_red_second;
    logic [7:0]       o_green_second;
    logic [7:0]       o_blue_second;
    logic             o_row_end;
    logic             o_frame_end;

    ycbcr420_to_rgb_converter_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_luma_first   (i_luma_first),
        .i_luma_second  (i_luma_second),
        .i_blue_chroma  (i_blue_chroma),
        .i_red_chroma   (i_red_chroma),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red_first    (o_red_first),
        .o_green_first  (o_green_first),
        .o_blue_first   (o_blue_first),
        .o_red_second   (o_red_second),
        .o_green_second (o_green_second),
        .o_blue_second  (o_blue_second),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_ycc_pair pair_queue[$];    // words waiting for the driver
    t_rgb_pair rgb_expected[$];  // predicted output words, oldest first

    bit  idling_on      = 1'b0;  // random gaps on both sides
    int  hold_token     = 0;     // bump to request one long receiver hold-off
    bit  pair_accepted  = 1'b0;  // input word taken at the last rising edge
    int  mismatches     = 0;
    int  words_checked  = 0;
    int  quiet_cycles   = 0;
    int  random_items   = 0;

    // Converter state as the testbench sees it
    logic [CFG_W-1:0] fmt_width;
    logic [CFG_W-1:0] fmt_height;
    logic [10:0]      pair_col;
    logic [11:0]      row_idx;
    logic [15:0]      chroma_store [0:LINE_DEPTH-1];  // {Cr, Cb}
    bit               chroma_seen  [0:LINE_DEPTH-1];

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int pairs_for(input logic [CFG_W-1:0] w);
        int n;
        n = (int'(w) + 1) >> 1;
        if (n < 1) begin
            n = 1;
        end
        if (n > LINE_DEPTH) begin
            n = LINE_DEPTH;
        end
        return n;
    endfunction

    function automatic int rows_for(input logic [CFG_W-1:0] h);
        int n;
        n = int'(h);
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_ROWS) begin
            n = MAX_ROWS;
        end
        return n;
    endfunction

    // Negative sums go to zero; otherwise drop the fraction and saturate
    function automatic logic [7:0] to_channel(input int acc);
        int whole;
        if (acc < 0) begin
            return 8'd0;
        end
        whole = acc >>> 16;
        return (whole > 255) ? 8'd255 : whole[7:0];
    endfunction

    function automatic void convert_pixel(input logic [7:0] y, input int u, input int v,
                                          output logic [7:0] r, output logic [7:0] g,
                                          output logic [7:0] b);
        int ys;
        ys = COEF_Y * (int'(y) - 16);
        r  = to_channel(ys + COEF_RV * v);
        g  = to_channel(ys - COEF_GU * u - COEF_GV * v);
        b  = to_channel(ys + COEF_BU * u);
    endfunction

    // Advance the converter state by one accepted pair and queue its RGB word
    function automatic void convert_pair(input t_ycc_pair p);
        t_rgb_pair  want;
        int         pairs;
        int         rows;
        int         u;
        int         v;
        logic [7:0] cb;
        logic [7:0] cr;
        bit         last_col;
        bit         last_row;
        pairs = pairs_for(fmt_width);
        rows  = rows_for(fmt_height);
        if (!row_idx[0]) begin
            // Even row: take the input chroma and keep it for the odd row below
            cb = p.blue_chroma;
            cr = p.red_chroma;
            chroma_store[pair_col] = {cr, cb};
            chroma_seen[pair_col]  = 1'b1;
        end else begin
            {cr, cb} = chroma_store[pair_col];
        end
        u = int'(cb) - 128;
        v = int'(cr) - 128;
        convert_pixel(p.luma_first, u, v, want.red_first, want.green_first, want.blue_first);
        convert_pixel(p.luma_second, u, v, want.red_second, want.green_second,
                      want.blue_second);
        last_col       = (int'(pair_col) + 1 >= pairs);
        last_row       = (int'(row_idx) + 1 >= rows);
        want.row_end   = last_col;
        want.frame_end = last_col && last_row;
        rgb_expected.push_back(want);
        if (last_col) begin
            pair_col = '0;
            row_idx  = last_row ? 12'd0 : row_idx + 12'd1;
        end else begin
            pair_col = pair_col + 11'd1;
        end
    endfunction

    // An odd row must only read columns that some even row has written
    function automatic bit width_change_safe(input logic [CFG_W-1:0] w);
        int n;
        if (!row_idx[0]) begin
            return 1'b1;
        end
        n = pairs_for(w);
        for (int k = int'(pair_col); k < n; k++) begin
            if (!chroma_seen[k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at word %0d (t=%0t): %s got %0d, want %0d",
                 words_checked, $time, what, got, want);
    endtask

    task automatic check_word();
        t_rgb_pair want;
        if (rgb_expected.size() == 0) begin
            report_mismatch("word with nothing expected", 1, 0);
            return;
        end
        want = rgb_expected.pop_front();
        if (o_red_first !== want.red_first)
            report_mismatch("red_first", o_red_first, want.red_first);
        if (o_green_first !== want.green_first)
            report_mismatch("green_first", o_green_first, want.green_first);
        if (o_blue_first !== want.blue_first)
            report_mismatch("blue_first", o_blue_first, want.blue_first);
        if (o_red_second !== want.red_second)
            report_mismatch("red_second", o_red_second, want.red_second);
        if (o_green_second !== want.green_second)
            report_mismatch("green_second", o_green_second, want.green_second);
        if (o_blue_second !== want.blue_second)
            report_mismatch("blue_second", o_blue_second, want.blue_second);
        if (o_row_end !== want.row_end)
            report_mismatch("row_end", o_row_end, want.row_end);
        if (o_frame_end !== want.frame_end)
            report_mismatch("frame_end", o_frame_end, want.frame_end);
        words_checked++;
    endtask

    // Sample both handshakes at the rising edge; predict on input, check on output
    always @(posedge i_clk) begin : monitor
        t_ycc_pair taken;
        bit        in_fire;
        bit        out_fire;
        in_fire  = i_rst_n && i_valid && o_ready;
        out_fire = i_rst_n && o_valid && i_ready;
        pair_accepted <= in_fire;
        if (in_fire) begin
            taken = {i_luma_first, i_luma_second, i_blue_chroma, i_red_chroma};
            convert_pair(taken);
        end
        if (out_fire) begin
            check_word();
        end
        // Watchdog: end the run if nothing moves for too long
        if (in_fire || out_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb_ycbcr420_to_rgb_converter_unit: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------
    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idling_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued words at the falling edge, hold until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        int        send_gap;
        t_ycc_pair nxt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else if (!i_valid || pair_accepted) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pair_queue.size() != 0) begin
                nxt = pair_queue.pop_front();
                i_valid       <= 1'b1;
                i_luma_first  <= nxt.luma_first;
                i_luma_second <= nxt.luma_second;
                i_blue_chroma <= nxt.blue_chroma;
                i_red_chroma  <= nxt.red_chroma;
                send_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : receiver
        int sink_wait;
        int hold_seen;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            sink_wait = 0;
            hold_seen = 0;
        end else begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0) begin
                sink_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                sink_wait = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Uniform values with extra weight on the range ends and studio levels
    function automatic logic [7:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 15);
        case (roll)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd16;
            3:       return 8'd235;
            4:       return 8'd128;
            5:       return 8'd240;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_ycc_pair random_pair();
        t_ycc_pair p;
        p.luma_first  = pick_sample();
        p.luma_second = pick_sample();
        p.blue_chroma = pick_sample();
        p.red_chroma  = pick_sample();
        return p;
    endfunction

    task automatic push_pair(input logic [7:0] y0, input logic [7:0] y1,
                             input logic [7:0] cb, input logic [7:0] cr);
        pair_queue.push_back({y0, y1, cb, cr});
    endtask

    // Hold the sender until every queued word has been taken and answered;
    // look just after the falling edge so a word the driver has just put up counts
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (pair_queue.size() != 0 || i_valid || rgb_expected.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_FRAME_WIDTH) begin
            fmt_width = val;
        end else begin
            fmt_height = val;
        end
    endtask

    // Change the frame format while the unit is idle. If the new width would
    // make an odd row read columns no even row has filled, finish that row first.
    task automatic apply_format(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        int pairs;
        int left;
        wait_idle();
        if (!width_change_safe(w)) begin
            pairs = pairs_for(fmt_width);
            left  = (int'(pair_col) >= pairs) ? 1 : pairs - int'(pair_col);
            repeat (left) pair_queue.push_back(random_pair());
            wait_idle();
        end
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_format(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input int n, input bit with_gaps);
        apply_format(w, h);
        idling_on = with_gaps;
        repeat (n) pair_queue.push_back(random_pair());
        random_items += n;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int w;
        int h;
        int n;
        fmt_width  = WIDTH_RESET;
        fmt_height = HEIGHT_RESET;
        pair_col   = '0;
        row_idx    = '0;
        foreach (chroma_seen[k]) chroma_seen[k] = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset format (640 x 480), even row: range ends of luma and chroma
        push_pair(8'd0,   8'd255, 8'd0,   8'd0);
        push_pair(8'd255, 8'd0,   8'd255, 8'd255);
        push_pair(8'd16,  8'd235, 8'd128, 8'd128);
        push_pair(8'd235, 8'd16,  8'd16,  8'd240);
        push_pair(8'd255, 8'd255, 8'd255, 8'd0);
        push_pair(8'd0,   8'd0,   8'd0,   8'd255);
        push_pair(8'd128, 8'd128, 8'd128, 8'd128);

        // Shrink to 2 pairs mid-row: the column counter is past the new limit,
        // so the next pair ends the row
        apply_format(13'd4, 13'd3);
        push_pair(8'd85,  8'd170, 8'd170, 8'd85);
        // Odd row first: its chroma is ignored, columns 0 and 1 come from the store
        push_pair(8'd255, 8'd0,   8'd0,   8'd0);
        push_pair(8'd0,   8'd255, 8'd255, 8'd255);
        push_pair(8'd16,  8'd16,  8'd200, 8'd60);
        push_pair(8'd235, 8'd235, 8'd60,  8'd200);

        // Odd width rounds up to whole pairs; zero height means one row
        apply_format(13'd5, 13'd0);
        push_pair(8'd1,   8'd254, 8'd1,   8'd254);
        push_pair(8'd254, 8'd1,   8'd254, 8'd1);
        push_pair(8'd128, 8'd128, 8'd0,   8'd255);

        // Width one is a single pair per row
        apply_format(13'd1, 13'd2);
        push_pair(8'd90,  8'd200, 8'd240, 8'd16);
        push_pair(8'd200, 8'd90,  8'd0,   8'd0);

        // Width zero, height saturating at the row limit
        apply_format(13'd0, 13'h1FFF);
        push_pair(8'd255, 8'd255, 8'd128, 8'd128);
        push_pair(8'd0,   8'd0,   8'd128, 8'd128);

        // Widest rows: the line store limit and the saturating register value
        run_format(13'd4096, 13'd2, 60, 1'b1);
        run_format(13'h1FFF, 13'h1FFF, 150, 1'b0);

        // Shrink mid-row again, then hold the receiver off so the unit fills
        // and stalls its input; then let everything drain before the rest
        run_format(13'd6, 13'd4, 100, 1'b1);
        hold_token++;
        wait_idle();
        repeat (100) pair_queue.push_back(random_pair());
        random_items += 100;

        // One pair per row over many rows, then cut the height mid-frame:
        // the row counter is past the new limit, so the frame ends next pair
        run_format(13'd2, 13'h1FFF, 100, 1'b1);
        run_format(13'd2, 13'd7, 60, 1'b1);

        // Random formats, mostly small so that rows and frames end often
        while (random_items < RANDOM_GOAL) begin
            w = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 24) : $urandom_range(25, 300);
            h = $urandom_range(0, 6);
            n = $urandom_range(20, 90);
            run_format(w[CFG_W-1:0], h[CFG_W-1:0], n, $urandom_range(0, 3) != 0);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_ycbcr420_to_rgb_converter_unit: PASS");
        end else begin
            $display("tb_ycbcr420_to_rgb_converter_unit: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ycc2rgb_pkg.sv
sv/ycc2rgb_ram.sv
sv/ycbcr420_to_rgb_converter_unit.sv
sv/ycc2rgb_checker.sv
test/tb_ycbcr420_to_rgb_converter_unit.sv
